### sv/fvn_pkg.sv
// Shared types, constants and tables for the fractal value noise block.
// No dependencies; every other file refers to this package by scoped names.

package fvn_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int OCT_W       = 4;                 // octave count register width
    localparam int OCT_IDX_W   = $clog2(MAX_OCTAVES);
    localparam int CRD_W       = 32;
    localparam int FREQ_W      = 24;
    localparam int SCL_W       = 24;                // bits of the scaled coordinate that matter
    localparam int FRAC_W      = 16;
    localparam int OCTV_W      = 24;                // per-octave value, Q8.16
    localparam int ACC_W       = OCTV_W + MAX_OCTAVES;
    localparam int DIVD_W      = FRAC_W + MAX_OCTAVES;
    localparam int RECIP_K     = 31;
    localparam int NOISE_W     = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int REG_IDX_W   = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SEED      = 2'd0,
        REG_FREQUENCY = 2'd1,
        REG_OCTAVES   = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SCL_W-1:0] sx;
        logic [SCL_W-1:0] sy;
    } t_qdata;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // floor(2^31 / (2^n - 1)) for n = 1..MAX_OCTAVES
    localparam logic [31:0] RECIP [MAX_OCTAVES] = '{
        32'd2147483648, 32'd715827882, 32'd306783378, 32'd143165576,
        32'd69273666,   32'd34087042,  32'd16909320,  32'd8421504
    };

    localparam logic [7:0] PERM [256] = '{
        8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,
        8'd161, 8'd78,  8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254,
        8'd245, 8'd255, 8'd247, 8'd247, 8'd40,  8'd185, 8'd248, 8'd251,
        8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,  8'd36,  8'd1,
        8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
        8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174,
        8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
        8'd167, 8'd44,  8'd43,  8'd77,  8'd180, 8'd204, 8'd8,   8'd81,
        8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254, 8'd210, 8'd210,
        8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
        8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,
        8'd47,  8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
        8'd181, 8'd235, 8'd193, 8'd206, 8'd70,  8'd180, 8'd174, 8'd0,
        8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116, 8'd127, 8'd198,
        8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
        8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
        8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195,
        8'd38,  8'd58,  8'd65,  8'd207, 8'd215, 8'd253, 8'd65,  8'd85,
        8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,  8'd89,  8'd232,
        8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
        8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187,
        8'd234, 8'd177, 8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143,
        8'd97,  8'd53,  8'd145, 8'd135, 8'd19,  8'd103, 8'd13,  8'd90,
        8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247, 8'd33,  8'd39,
        8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
        8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158,
        8'd42,  8'd30,  8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135,
        8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21,  8'd233,
        8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128, 8'd211, 8'd118,
        8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
        8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250,
        8'd209, 8'd92,  8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
    };

endpackage

### sv/fvn_front.sv
// Front end: input transfer, coordinate register and frequency scaling.
// Depends on fvn_pkg; pushes scaled coordinates into fvn_queue.

module fvn_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [fvn_pkg::CRD_W-1:0]     i_x_coord,
    input  logic [fvn_pkg::CRD_W-1:0]     i_y_coord,
    input  logic [fvn_pkg::FREQ_W-1:0]    i_frequency,
    input  fvn_pkg::t_qstat               i_qstat,
    output logic                          o_push,
    output fvn_pkg::t_qdata               o_qdata
);

    localparam int PROD_W = fvn_pkg::CRD_W + fvn_pkg::FREQ_W;

    logic                        r_vld;
    logic [fvn_pkg::CRD_W-1:0]   r_x;
    logic [fvn_pkg::CRD_W-1:0]   r_y;
    logic [PROD_W-1:0]           w_px;
    logic [PROD_W-1:0]           w_py;

    assign o_ready = !r_vld || !i_qstat.full;
    assign o_push  = r_vld && !i_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x <= i_x_coord;
            r_y <= i_y_coord;
        end
    end

    // only bits 16..39 of the product survive the octave shifts and mod-256 wrap
    assign w_px = PROD_W'(r_x) * PROD_W'(i_frequency);
    assign w_py = PROD_W'(r_y) * PROD_W'(i_frequency);
    assign o_qdata.sx = w_px[fvn_pkg::FRAC_W +: fvn_pkg::SCL_W];
    assign o_qdata.sy = w_py[fvn_pkg::FRAC_W +: fvn_pkg::SCL_W];

endmodule

### sv/fvn_queue.sv
// Short FIFO between front and back end.
// Depends on fvn_pkg for the entry type and depth.

module fvn_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fvn_pkg::t_qdata  i_data,
    input  logic             i_pop,
    output fvn_pkg::t_qdata  o_data,
    output fvn_pkg::t_qstat  o_stat
);

    fvn_pkg::t_qdata                r_mem [fvn_pkg::QDEPTH];
    logic [fvn_pkg::QPTR_W-1:0]     r_wptr;
    logic [fvn_pkg::QPTR_W-1:0]     r_rptr;
    logic [fvn_pkg::QPTR_W:0]       r_cnt;

    assign o_stat.full  = (r_cnt == (fvn_pkg::QPTR_W+1)'(fvn_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### sv/fvn_back.sv
// Back end: per-octave lanes (hash, smoothstep, blend), sum and normalize.
// Depends on fvn_pkg for the permutation ROM, reciprocal table and widths.

module fvn_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fvn_pkg::t_qdata                   i_qdata,
    input  fvn_pkg::t_qstat                   i_qstat,
    output logic                              o_pop,
    input  logic [7:0]                        i_seed,
    input  logic [fvn_pkg::OCT_W-1:0]         i_oct_n,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [fvn_pkg::NOISE_W-1:0]       o_noise_value
);

    localparam int NSTG = 7;
    localparam int MAXO = fvn_pkg::MAX_OCTAVES;
    localparam int AW   = fvn_pkg::DIVD_W;

    logic [NSTG:1]                  r_vld;
    logic                           w_en;
    logic [fvn_pkg::OCTV_W-1:0]     w_val [MAXO];

    assign w_en  = !r_vld[NSTG] || i_ready;
    assign o_pop = w_en && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-1:1], !i_qstat.empty};
        end
    end

    // ---- octave lanes, stages 1 to 4 ----
    for (genvar g = 0; g < MAXO; g++) begin : g_lane
        logic [fvn_pkg::SCL_W-1:0]  lx, ly;
        logic [31:0]                sqx, sqy;
        logic [7:0]                 r1_ix, r1_rowa, r1_rowb;
        logic [15:0]                r1_fx, r1_fy, r1_f2x, r1_f2y;
        logic [17:0]                kx, ky;
        logic [33:0]                pwx, pwy;
        logic [15:0]                r2_wx, r2_wy;
        logic [7:0]                 r2_s, r2_t, r2_u, r2_v;
        logic signed [8:0]          dts, dvu;
        logic signed [25:0]         plo, phi, slo, shi;
        logic [23:0]                r3_lo, r3_hi;
        logic [15:0]                r3_wy;
        logic signed [24:0]         dhl;
        logic signed [41:0]         pm, mix;
        logic [23:0]                r4_val;

        assign lx  = i_qdata.sx << g;
        assign ly  = i_qdata.sy << g;
        assign sqx = lx[15:0] * lx[15:0];
        assign sqy = ly[15:0] * ly[15:0];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r1_ix   <= lx[23:16];
                r1_fx   <= lx[15:0];
                r1_fy   <= ly[15:0];
                r1_f2x  <= sqx[31:16];
                r1_f2y  <= sqy[31:16];
                r1_rowa <= fvn_pkg::PERM[8'(ly[23:16] + i_seed)];
                r1_rowb <= fvn_pkg::PERM[8'(ly[23:16] + 8'd1 + i_seed)];
            end
        end

        // smoothstep: f^2 * (3 - 2f)
        assign kx  = 18'd196608 - {1'b0, r1_fx, 1'b0};
        assign ky  = 18'd196608 - {1'b0, r1_fy, 1'b0};
        assign pwx = r1_f2x * kx;
        assign pwy = r1_f2y * ky;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r2_wx <= pwx[31:16];
                r2_wy <= pwy[31:16];
                r2_s  <= fvn_pkg::PERM[8'(r1_rowa + r1_ix)];
                r2_t  <= fvn_pkg::PERM[8'(r1_rowa + r1_ix + 8'd1)];
                r2_u  <= fvn_pkg::PERM[8'(r1_rowb + r1_ix)];
                r2_v  <= fvn_pkg::PERM[8'(r1_rowb + r1_ix + 8'd1)];
            end
        end

        assign dts = $signed({1'b0, r2_t}) - $signed({1'b0, r2_s});
        assign dvu = $signed({1'b0, r2_v}) - $signed({1'b0, r2_u});
        assign plo = $signed({1'b0, r2_wx}) * dts;
        assign phi = $signed({1'b0, r2_wx}) * dvu;
        assign slo = $signed({2'b00, r2_s, 16'h0000}) + plo;
        assign shi = $signed({2'b00, r2_u, 16'h0000}) + phi;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r3_lo <= slo[23:0];
                r3_hi <= shi[23:0];
                r3_wy <= r2_wy;
            end
        end

        assign dhl = $signed({1'b0, r3_hi}) - $signed({1'b0, r3_lo});
        assign pm  = $signed({1'b0, r3_wy}) * dhl;
        assign mix = $signed({2'b00, r3_lo, 16'h0000}) + pm;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r4_val <= mix[39:16];
            end
        end

        assign w_val[g] = r4_val;
    end

    // ---- stage 5: weighted sum, prescale by 2^(n-1) / 2^(MAXO+7) ----
    logic [fvn_pkg::ACC_W-1:0]      w_acc;
    logic [4:0]                     w_sh;
    logic [fvn_pkg::ACC_W-1:0]      w_accs;
    logic [AW-1:0]                  r5_a;

    always_comb begin
        w_acc = '0;
        for (int i = 0; i < MAXO; i++) begin
            if (i < 32'(i_oct_n)) begin
                w_acc = w_acc + (fvn_pkg::ACC_W'(w_val[i]) << (MAXO - 1 - i));
            end
        end
    end

    assign w_sh   = 5'(MAXO + 8) - 5'(i_oct_n);
    assign w_accs = w_acc >> w_sh;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_a <= w_accs[AW-1:0];
        end
    end

    // ---- stage 6: quotient estimate by reciprocal of 2^n - 1 ----
    logic [fvn_pkg::OCT_W-1:0]      w_nm1;
    logic [AW+31:0]                 w_prod;
    logic [fvn_pkg::NOISE_W-1:0]    r6_q;
    logic [AW-1:0]                  r6_a;

    assign w_nm1  = i_oct_n - 1'b1;
    assign w_prod = (AW+32)'(r5_a) * (AW+32)'(fvn_pkg::RECIP[w_nm1[fvn_pkg::OCT_IDX_W-1:0]]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_q <= w_prod[fvn_pkg::RECIP_K +: fvn_pkg::NOISE_W];
            r6_a <= r5_a;
        end
    end

    // ---- stage 7: estimate is low by at most one ----
    logic [AW-1:0]                  w_div;
    logic [AW-1:0]                  w_qd;
    logic [AW-1:0]                  w_rem;
    logic [fvn_pkg::NOISE_W-1:0]    r7_q;

    assign w_div = (AW'(1) << i_oct_n) - AW'(1);
    assign w_qd  = (AW'(r6_q) << i_oct_n) - AW'(r6_q);
    assign w_rem = r6_a - w_qd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_q <= (w_rem >= w_div) ? r6_q + 1'b1 : r6_q;
        end
    end

    assign o_valid       = r_vld[NSTG];
    assign o_noise_value = r7_q;

endmodule

### sv/fractal_value_noise_2d.sv
// Fractal value noise 2D: one Q16.16 (x, y) sample in, one Q0.16 value out.
// Throughput one sample per cycle while the output is not stalled; all octaves run in parallel lanes.
// The front register loads at the input transfer edge; the sample then passes a queue entry and
// seven back-end stages before the result is valid. Output stalls hold the whole back end.
// Synchronous active-low reset: seed 0, frequency 1.0, 4 octaves, queue empty.
// Depends on fvn_pkg, fvn_front, fvn_queue, fvn_back.

module fractal_value_noise_2d (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fvn_pkg::ADDR_W-1:0]         paddr,
    input  logic [fvn_pkg::DATA_W-1:0]         pwdata,
    output logic [fvn_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // sample input
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [fvn_pkg::CRD_W-1:0]          i_x_coord,
    input  logic [fvn_pkg::CRD_W-1:0]          i_y_coord,
    // result output
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [fvn_pkg::NOISE_W-1:0]        o_noise_value
);

    // configuration registers
    logic [7:0]                       r_seed;
    logic [fvn_pkg::FREQ_W-1:0]       r_freq;
    logic [fvn_pkg::OCT_W-1:0]        r_oct;
    fvn_pkg::t_reg_idx                w_idx;
    logic                             w_wr;
    logic [fvn_pkg::OCT_W-1:0]        w_oct_n;

    assign pready = 1'b1;
    assign w_idx  = fvn_pkg::t_reg_idx'(paddr[fvn_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_freq <= fvn_pkg::FREQ_W'(65536);
            r_oct  <= fvn_pkg::OCT_W'(4);
        end else if (w_wr) begin
            unique case (w_idx)
                fvn_pkg::REG_SEED:      r_seed <= pwdata[7:0];
                fvn_pkg::REG_FREQUENCY: r_freq <= pwdata[fvn_pkg::FREQ_W-1:0];
                fvn_pkg::REG_OCTAVES:   r_oct  <= pwdata[fvn_pkg::OCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            fvn_pkg::REG_SEED:      prdata = fvn_pkg::DATA_W'(r_seed);
            fvn_pkg::REG_FREQUENCY: prdata = fvn_pkg::DATA_W'(r_freq);
            fvn_pkg::REG_OCTAVES:   prdata = fvn_pkg::DATA_W'(r_oct);
            default:                prdata = '0;
        endcase
    end

    // octave count clamped to 1..MAX_OCTAVES
    always_comb begin
        priority if (r_oct == '0) begin
            w_oct_n = fvn_pkg::OCT_W'(1);
        end else if (r_oct > fvn_pkg::OCT_W'(fvn_pkg::MAX_OCTAVES)) begin
            w_oct_n = fvn_pkg::OCT_W'(fvn_pkg::MAX_OCTAVES);
        end else begin
            w_oct_n = r_oct;
        end
    end

    // front -> queue -> back
    fvn_pkg::t_qdata   w_push_data;
    fvn_pkg::t_qdata   w_pop_data;
    fvn_pkg::t_qstat   w_qstat;
    logic              w_push;
    logic              w_pop;

    fvn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_frequency (r_freq),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_qdata     (w_push_data)
    );

    fvn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_stat  (w_qstat)
    );

    fvn_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qdata       (w_pop_data),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .i_seed        (r_seed),
        .i_oct_n       (w_oct_n),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_noise_value (o_noise_value)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("queue push while full");

    // back end only takes from a non-empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("queue pop while empty");

    // clamped octave count stays in 1..MAX_OCTAVES
    a_oct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_oct_n != '0) && (w_oct_n <= fvn_pkg::OCT_W'(fvn_pkg::MAX_OCTAVES)))
        else $error("octave count out of range");

endmodule
